>>> sv/kmdr_pkg.sv
// Shared types, constants and register codes of the key matrix debounce and repeat block.
`default_nettype none
package kmdr_pkg;

  localparam int ROWS_DEF = 8;
  localparam int COLS_DEF = 8;

  localparam int COL_W  = 3;
  localparam int BITS_W = 8;
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int REG_IDX_W = 2;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;

  localparam logic [MS_W-1:0] DEBOUNCE_RST       = 16'd20;
  localparam logic [MS_W-1:0] REPEAT_DELAY_RST   = 16'd500;
  localparam logic [MS_W-1:0] REPEAT_INTERVAL_RST = 16'd50;
  localparam logic            EVENTS_ENABLE_RST  = 1'b1;

  typedef logic [TIME_W-1:0] ms_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DEBOUNCE        = 2'd0,
    REG_REPEAT_DELAY    = 2'd1,
    REG_REPEAT_INTERVAL = 2'd2,
    REG_EVENTS_ENABLE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] rpt_delay;
    logic [MS_W-1:0] rpt_period;
    logic            events_enable;
  } cfg_t;

endpackage
`default_nettype wire

>>> sv/key_matrix_debounce_repeat.sv
// Top level of the key matrix debounce and auto-repeat block.
//
// Each input item is one sampled matrix column (index, raw pressed flags of its rows and a
// millisecond timestamp); each yields exactly one result item with the column index and the
// press, repeat and held masks of that column after the update. The block takes one item per
// clock while results are taken, passing through an input register, then one pass of per-row
// subtract-and-compare logic that reads and rewrites the column's state registers in the same
// cycle, then the result register. A result held back by the receiver keeps the next item in
// the input register, and input stalls once both registers are full. A column index of COLS
// or above leaves the state alone and returns zero masks. Configuration is to be written through
// cfg_wen/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce this.
`default_nettype none
module key_matrix_debounce_repeat #(
  parameter int ROWS = kmdr_pkg::ROWS_DEF,
  parameter int COLS = kmdr_pkg::COLS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [kmdr_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  wire logic [kmdr_pkg::MS_W-1:0]           cfg_wdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // column [2:0], row_pressed_bits [10:3], now_ms [42:11], zero fill [47:43]
  input  wire logic [kmdr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // event_column [2:0], press_mask [10:3], repeat_mask [18:11], held_mask [26:19], zero [31:27]
  output logic [kmdr_pkg::M_TDATA_W-1:0]           m_axis_tdata
);

  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  kmdr_pkg::cfg_t cfg;

  logic                          s1_valid;
  logic [kmdr_pkg::COL_W-1:0]    s1_column;
  logic [kmdr_pkg::BITS_W-1:0]   s1_bits;
  kmdr_pkg::ms_t                 s1_now;
  logic                          advance;
  logic                          in_range;
  logic [CW-1:0]                 col_idx;

  logic [ROWS-1:0]               rd_state;
  kmdr_pkg::ms_t [ROWS-1:0]      rd_change;
  kmdr_pkg::ms_t [ROWS-1:0]      rd_repeat;
  logic [ROWS-1:0]               st_next;
  kmdr_pkg::ms_t [ROWS-1:0]      change_next;
  kmdr_pkg::ms_t [ROWS-1:0]      rpt_next;
  logic [kmdr_pkg::BITS_W-1:0]   press_mask;
  logic [kmdr_pkg::BITS_W-1:0]   repeat_mask;
  logic [kmdr_pkg::BITS_W-1:0]   held_mask;

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign in_range      = int'(s1_column) < COLS;
  assign col_idx       = CW'(s1_column);

  kmdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kmdr_key_store #(
    .ROWS (ROWS),
    .COLS (COLS),
    .CW   (CW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .col_idx   (col_idx),
    .rd_state  (rd_state),
    .rd_change (rd_change),
    .rd_repeat (rd_repeat),
    .wr_en     (advance && in_range),
    .wr_state  (st_next),
    .wr_change (change_next),
    .wr_repeat (rpt_next)
  );

  kmdr_col_update #(
    .ROWS (ROWS)
  ) u_update (
    .cfg         (cfg),
    .raw_bits    (s1_bits),
    .now_ms      (s1_now),
    .st          (rd_state),
    .change      (rd_change),
    .rpt         (rd_repeat),
    .st_next     (st_next),
    .change_next (change_next),
    .rpt_next    (rpt_next),
    .press_mask  (press_mask),
    .repeat_mask (repeat_mask),
    .held_mask   (held_mask)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_column <= s_axis_tdata[2:0];
      s1_bits   <= s_axis_tdata[10:3];
      s1_now    <= s_axis_tdata[42:11];
    end
  end

  // Result register; loads a waiting item if empty or if its item leaves in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'd0,
                       in_range ? held_mask   : 8'd0,
                       in_range ? repeat_mask : 8'd0,
                       in_range ? press_mask  : 8'd0,
                       s1_column};
    end
  end

endmodule
`default_nettype wire

>>> sv/kmdr_cfg_regs.sv
// Configuration registers: debounce time, repeat delay, repeat interval and event enable.
`default_nettype none
module kmdr_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [kmdr_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  wire logic [kmdr_pkg::MS_W-1:0]          cfg_wdata,
  output kmdr_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= kmdr_pkg::DEBOUNCE_RST;
      cfg.rpt_delay     <= kmdr_pkg::REPEAT_DELAY_RST;
      cfg.rpt_period    <= kmdr_pkg::REPEAT_INTERVAL_RST;
      cfg.events_enable <= kmdr_pkg::EVENTS_ENABLE_RST;
    end else if (cfg_wen) begin
      unique case (kmdr_pkg::cfg_reg_t'(cfg_addr))
        kmdr_pkg::REG_DEBOUNCE:        cfg.debounce_ms   <= cfg_wdata;
        kmdr_pkg::REG_REPEAT_DELAY:    cfg.rpt_delay     <= cfg_wdata;
        kmdr_pkg::REG_REPEAT_INTERVAL: cfg.rpt_period    <= cfg_wdata;
        kmdr_pkg::REG_EVENTS_ENABLE:   cfg.events_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/kmdr_key_store.sv
// Per-column key state: debounced level, last change time and last repeat time of every row.
`default_nettype none
module kmdr_key_store #(
  parameter int ROWS = kmdr_pkg::ROWS_DEF,
  parameter int COLS = kmdr_pkg::COLS_DEF,
  parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [CW-1:0]                  col_idx,
  output logic [ROWS-1:0]                     rd_state,
  output kmdr_pkg::ms_t [ROWS-1:0]            rd_change,
  output kmdr_pkg::ms_t [ROWS-1:0]            rd_repeat,
  input  wire logic                           wr_en,
  input  wire logic [ROWS-1:0]                wr_state,
  input  wire kmdr_pkg::ms_t [ROWS-1:0]       wr_change,
  input  wire kmdr_pkg::ms_t [ROWS-1:0]       wr_repeat
);

  logic [ROWS-1:0]          state_q  [COLS];
  kmdr_pkg::ms_t [ROWS-1:0] change_q [COLS];
  kmdr_pkg::ms_t [ROWS-1:0] repeat_q [COLS];

  assign rd_state  = state_q[col_idx];
  assign rd_change = change_q[col_idx];
  assign rd_repeat = repeat_q[col_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLS; c++) begin
        state_q[c]  <= '0;
        change_q[c] <= '0;
        repeat_q[c] <= '0;
      end
    end else if (wr_en) begin
      state_q[col_idx]  <= wr_state;
      change_q[col_idx] <= wr_change;
      repeat_q[col_idx] <= wr_repeat;
    end
  end

endmodule
`default_nettype wire

>>> sv/kmdr_col_update.sv
// Debounce and auto-repeat update of all rows of one column, side by side.
`default_nettype none
module kmdr_col_update #(
  parameter int ROWS = kmdr_pkg::ROWS_DEF
) (
  input  wire kmdr_pkg::cfg_t                 cfg,
  input  wire logic [kmdr_pkg::BITS_W-1:0]    raw_bits,
  input  wire kmdr_pkg::ms_t                  now_ms,
  input  wire logic [ROWS-1:0]                st,
  input  wire kmdr_pkg::ms_t [ROWS-1:0]       change,
  input  wire kmdr_pkg::ms_t [ROWS-1:0]       rpt,
  output logic [ROWS-1:0]                     st_next,
  output kmdr_pkg::ms_t [ROWS-1:0]            change_next,
  output kmdr_pkg::ms_t [ROWS-1:0]            rpt_next,
  output logic [kmdr_pkg::BITS_W-1:0]         press_mask,
  output logic [kmdr_pkg::BITS_W-1:0]         repeat_mask,
  output logic [kmdr_pkg::BITS_W-1:0]         held_mask
);

  logic [ROWS-1:0] raw;
  logic [ROWS-1:0] press;
  logic [ROWS-1:0] rep;

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    kmdr_pkg::ms_t hold;
    kmdr_pkg::ms_t since;

    // Rows beyond the sampled width always read released.
    if (r < kmdr_pkg::BITS_W) begin : g_raw
      assign raw[r] = raw_bits[r];
    end else begin : g_noraw
      assign raw[r] = 1'b0;
    end

    assign hold  = now_ms - change[r];
    assign since = now_ms - rpt[r];

    always_comb begin
      st_next[r]     = st[r];
      change_next[r] = change[r];
      rpt_next[r]    = rpt[r];
      press[r]       = 1'b0;
      rep[r]         = 1'b0;
      if (raw[r] != st[r]) begin
        if (hold > kmdr_pkg::ms_t'(cfg.debounce_ms)) begin
          st_next[r]     = raw[r];
          change_next[r] = now_ms;
          rpt_next[r]    = raw[r] ? now_ms : '0;
          press[r]       = raw[r] & cfg.events_enable;
        end
      end else if (raw[r] && cfg.events_enable) begin
        if (hold >= kmdr_pkg::ms_t'(cfg.rpt_delay) &&
            since >= kmdr_pkg::ms_t'(cfg.rpt_period)) begin
          rpt_next[r] = now_ms;
          rep[r]      = 1'b1;
        end
      end
    end
  end

  for (genvar b = 0; b < kmdr_pkg::BITS_W; b++) begin : g_mask
    if (b < ROWS) begin : g_live
      assign press_mask[b]  = press[b];
      assign repeat_mask[b] = rep[b];
      assign held_mask[b]   = st_next[b];
    end else begin : g_dead
      assign press_mask[b]  = 1'b0;
      assign repeat_mask[b] = 1'b0;
      assign held_mask[b]   = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_key_matrix_debounce_repeat.sv
// Self-checking testbench that predicts each column scan result and compares it to the block.
`timescale 1ns / 100ps
module tb_key_matrix_debounce_repeat;

  typedef struct packed {
    logic [kmdr_pkg::COL_W-1:0]  column;
    logic [kmdr_pkg::BITS_W-1:0] press;
    logic [kmdr_pkg::BITS_W-1:0] rpt;
    logic [kmdr_pkg::BITS_W-1:0] held;
  } col_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wen = 1'b0;
  logic [kmdr_pkg::REG_IDX_W-1:0] cfg_addr = '0;
  logic [kmdr_pkg::MS_W-1:0]      cfg_wdata = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [kmdr_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [kmdr_pkg::M_TDATA_W-1:0] m_axis_tdata;

  key_matrix_debounce_repeat dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predicted key state, one entry per column and row.
  kmdr_pkg::cfg_t              reg_model;
  logic [kmdr_pkg::BITS_W-1:0] key_down [kmdr_pkg::COLS_DEF];
  kmdr_pkg::ms_t               changed_at [kmdr_pkg::COLS_DEF][kmdr_pkg::BITS_W];
  kmdr_pkg::ms_t               repeated_at [kmdr_pkg::COLS_DEF][kmdr_pkg::BITS_W];

  logic [kmdr_pkg::S_TDATA_W-1:0] scan_queue [$];
  col_result_t                    pending_results [$];
  int                             scans_queued = 0;
  int                             scans_taken = 0;
  int                             results_seen = 0;
  int                             mismatches = 0;
  int                             src_gap_max = 13;
  int                             sink_wait_max = 13;
  logic                           in_taken = 1'b0;
  logic                           out_taken = 1'b0;

  // Stimulus state: time base, scan position and the level each column is meant to show.
  kmdr_pkg::ms_t               clock_ms = '0;
  logic [kmdr_pkg::COL_W-1:0]  scan_col = '0;
  logic [kmdr_pkg::BITS_W-1:0] intent [kmdr_pkg::COLS_DEF];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic scan_column(input logic [kmdr_pkg::COL_W-1:0] col,
                             input logic [kmdr_pkg::BITS_W-1:0] raw,
                             input kmdr_pkg::ms_t now);
    col_result_t   res;
    kmdr_pkg::ms_t hold;
    kmdr_pkg::ms_t since;
    res = '0;
    res.column = col;
    if (col < kmdr_pkg::COLS_DEF) begin
      for (int r = 0; r < kmdr_pkg::BITS_W; r++) begin
        if (raw[r] != key_down[col][r]) begin
          hold = now - changed_at[col][r];
          if (hold > kmdr_pkg::ms_t'(reg_model.debounce_ms)) begin
            changed_at[col][r] = now;
            key_down[col][r] = raw[r];
            // A release clears the repeat time; a press restarts it.
            repeated_at[col][r] = raw[r] ? now : '0;
            if (reg_model.events_enable && raw[r])
              res.press[r] = 1'b1;
          end
        end else if (raw[r] && reg_model.events_enable) begin
          hold = now - changed_at[col][r];
          since = now - repeated_at[col][r];
          if (hold >= kmdr_pkg::ms_t'(reg_model.rpt_delay) &&
              since >= kmdr_pkg::ms_t'(reg_model.rpt_period)) begin
            repeated_at[col][r] = now;
            res.rpt[r] = 1'b1;
          end
        end
      end
      res.held = key_down[col];
    end
    pending_results.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
  endtask

  task automatic push_scan(input logic [kmdr_pkg::COL_W-1:0] col,
                           input logic [kmdr_pkg::BITS_W-1:0] bits,
                           input kmdr_pkg::ms_t now);
    scan_queue.push_back({5'b0, now, bits, col});
    scans_queued++;
  endtask

  // Mostly an in-order column scan with keys that change now and then, some contact bounce
  // and rare jumps of the time base.
  task automatic add_scans(input int count, input int dt_max);
    logic [kmdr_pkg::BITS_W-1:0] bits;
    logic [31:0]                 pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        scan_col = scan_col + 1'b1;
      end else begin
        pick = $urandom_range(0, kmdr_pkg::COLS_DEF - 1);
        scan_col = pick[kmdr_pkg::COL_W-1:0];
      end
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            pick = $urandom_range(0, 255);
            intent[scan_col] = pick[kmdr_pkg::BITS_W-1:0];
          end
          1: intent[scan_col] = intent[scan_col] ^ (8'd1 << $urandom_range(0, 7));
          2: intent[scan_col] = 8'hFF;
          default: intent[scan_col] = 8'h00;
        endcase
      end
      bits = intent[scan_col];
      if ($urandom_range(0, 9) == 0)
        bits = bits ^ 8'($urandom_range(0, 255));
      if ($urandom_range(0, 49) == 0)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + kmdr_pkg::ms_t'($urandom_range(0, dt_max));
      push_scan(scan_col, bits, clock_ms);
    end
  endtask

  task automatic wait_drain;
    while (scans_taken != scans_queued || pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input kmdr_pkg::cfg_reg_t idx,
                           input logic [kmdr_pkg::MS_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    unique case (idx)
      kmdr_pkg::REG_DEBOUNCE:        reg_model.debounce_ms = val;
      kmdr_pkg::REG_REPEAT_DELAY:    reg_model.rpt_delay = val;
      kmdr_pkg::REG_REPEAT_INTERVAL: reg_model.rpt_period = val;
      kmdr_pkg::REG_EVENTS_ENABLE:   reg_model.events_enable = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Sender: one item offered at a time, with a random gap after each accepted item.
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      scans_taken++;
      scan_column(s_axis_tdata[2:0], s_axis_tdata[10:3], s_axis_tdata[42:11]);
    end
  end

  bit offering = 1'b0;
  int src_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        offering = 1'b0;
        src_gap = $urandom_range(0, src_gap_max);
      end
      if (!offering) begin
        if (src_gap > 0)
          src_gap--;
        else if (scan_queue.size() > 0) begin
          s_axis_tdata <= scan_queue.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    col_result_t want;
    out_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] != want.column)
          flag_mismatch("event_column", want.column, m_axis_tdata[2:0]);
        if (m_axis_tdata[10:3] != want.press)
          flag_mismatch("press_mask", want.press, m_axis_tdata[10:3]);
        if (m_axis_tdata[18:11] != want.rpt)
          flag_mismatch("repeat_mask", want.rpt, m_axis_tdata[18:11]);
        if (m_axis_tdata[26:19] != want.held)
          flag_mismatch("held_mask", want.held, m_axis_tdata[26:19]);
      end
    end
  end

  // Receiver: random wait before each item, and two long hold-offs that back the block up.
  int sink_wait = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        sink_wait = $urandom_range(0, sink_wait_max);
        if (results_seen == 150 || results_seen == 800)
          sink_wait = 300;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int dt_max;
    int span;
    reg_model.debounce_ms = kmdr_pkg::DEBOUNCE_RST;
    reg_model.rpt_delay = kmdr_pkg::REPEAT_DELAY_RST;
    reg_model.rpt_period = kmdr_pkg::REPEAT_INTERVAL_RST;
    reg_model.events_enable = kmdr_pkg::EVENTS_ENABLE_RST;
    for (int c = 0; c < kmdr_pkg::COLS_DEF; c++) begin
      key_down[c] = '0;
      intent[c] = '0;
      for (int r = 0; r < kmdr_pkg::BITS_W; r++) begin
        changed_at[c][r] = '0;
        repeated_at[c][r] = '0;
      end
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed scans with the reset settings.
    push_scan(3'd0, 8'hFF, 32'd0);           // too soon after the reset change time
    push_scan(3'd0, 8'hFF, 32'd21);          // press accepted
    push_scan(3'd0, 8'h00, 32'd30);          // bounce inside the debounce window
    push_scan(3'd0, 8'hFF, 32'd520);         // one short of the repeat delay
    push_scan(3'd0, 8'hFF, 32'd521);
    push_scan(3'd0, 8'hFF, 32'd570);
    push_scan(3'd0, 8'hFF, 32'd571);
    push_scan(3'd0, 8'h0F, 32'd600);         // partial release
    push_scan(3'd0, 8'h0F, 32'd621);
    push_scan(3'd7, 8'hAA, 32'd700);
    push_scan(3'd7, 8'h55, 32'd721);         // release and press in one scan
    push_scan(3'd7, 8'h55, 32'd720);         // time steps back, so the hold wraps huge
    push_scan(3'd3, 8'h81, 32'hFFFF_FFFF);
    push_scan(3'd3, 8'h00, 32'h0000_0010);   // across the wrap, still inside the window
    push_scan(3'd3, 8'h00, 32'h0000_0014);
    push_scan(3'd5, 8'h01, 32'h8000_0000);
    push_scan(3'd2, 8'hFF, 32'h7FFF_FFFF);
    push_scan(3'd4, 8'h3C, 32'hAAAA_AAAA);
    push_scan(3'd6, 8'hC3, 32'h5555_5555);
    push_scan(3'd1, 8'hFF, 32'h0000_FFFF);
    clock_ms = 32'h0001_0000;

    for (int p = 0; p < 10; p++) begin
      wait_drain();
      case (p)
        0: ;
        1: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'd0);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'd0);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'd0);
        end
        2: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'hFFFF);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'hFFFF);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'hFFFF);
        end
        3: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'd20);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'd500);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'd50);
          write_reg(kmdr_pkg::REG_EVENTS_ENABLE, 16'hFFFE);  // only bit zero counts
        end
        4: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'd3);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'd40);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'd7);
          write_reg(kmdr_pkg::REG_EVENTS_ENABLE, 16'd1);
        end
        5: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'hFFFF);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'd0);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'd0);
        end
        6: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'd0);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'hFFFF);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'd1);
        end
        7: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'($urandom_range(0, 65535)));
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'($urandom_range(0, 65535)));
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'($urandom_range(0, 65535)));
          write_reg(kmdr_pkg::REG_EVENTS_ENABLE, 16'($urandom_range(0, 65535)));
        end
        8: begin
          write_reg(kmdr_pkg::REG_DEBOUNCE, 16'd10);
          write_reg(kmdr_pkg::REG_REPEAT_DELAY, 16'd200);
          write_reg(kmdr_pkg::REG_REPEAT_INTERVAL, 16'd30);
          write_reg(kmdr_pkg::REG_EVENTS_ENABLE, 16'd0);
        end
        default: begin
          // Keys left held while events were off pick up repeats again here.
          write_reg(kmdr_pkg::REG_EVENTS_ENABLE, 16'd1);
          clock_ms = 32'hFFFF_FE00;
        end
      endcase
      cfg_wen <= 1'b0;
      src_gap_max = (p inside {1, 4, 7}) ? 0 : 13;
      sink_wait_max = (p inside {2, 4, 8}) ? 0 : 13;
      span = int'(reg_model.debounce_ms);
      if (int'(reg_model.rpt_delay) / 8 > span)
        span = int'(reg_model.rpt_delay) / 8;
      if (int'(reg_model.rpt_period) > span)
        span = int'(reg_model.rpt_period);
      dt_max = span / 3 + 8;
      add_scans(113, dt_max);
    end

    wait_drain();
    repeat (10) @(negedge clk);
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/kmdr_pkg.sv
sv/kmdr_cfg_regs.sv
sv/kmdr_key_store.sv
sv/kmdr_col_update.sv
sv/key_matrix_debounce_repeat.sv
tb/tb_key_matrix_debounce_repeat.sv
